// ===== rtl/core/plst_pkg.sv =====
// ----------------------------------------------------------------------------
// plst_pkg
// Shared types and codes for the peer link state table: event kinds, link
// state codes and the input and result words.
// ----------------------------------------------------------------------------
package plst_pkg;

  // Default sizes
  localparam int LINKS_DEF     = 128;
  localparam int ADDR_BITS_DEF = 48;

  // Field widths of the channel words
  localparam int KIND_W  = 2;
  localparam int PADDR_W = 48;
  localparam int FTYPE_W = 8;
  localparam int ST_W    = 3;

  // Event kinds
  localparam logic [KIND_W-1:0] KIND_USER_CONN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_USER_DISC = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RPT_CONN  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RPT_DISC  = 2'd3;

  // Link state codes
  localparam logic [ST_W-1:0] ST_IDLE          = 3'd0;
  localparam logic [ST_W-1:0] ST_CONNECTING    = 3'd1;
  localparam logic [ST_W-1:0] ST_CONNECTED     = 3'd2;
  localparam logic [ST_W-1:0] ST_DISCONNECTING = 3'd3;
  localparam logic [ST_W-1:0] ST_DISCONNECTED  = 3'd4;

  // Input word
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [PADDR_W-1:0] peer_addr;
    logic [FTYPE_W-1:0] frame_type;
    logic               lower_ok;
  } plst_in_t;

  // Result word
  typedef struct packed {
    logic [ST_W-1:0]    link_state;
    logic               issue_add;
    logic               issue_remove;
    logic [FTYPE_W-1:0] cmd_frame_type;
    logic               table_full;
    logic               all_clear;
  } plst_out_t;

endpackage

// ===== rtl/core/plst_mem.sv =====
// ----------------------------------------------------------------------------
// plst_mem
// Entry store: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module plst_mem
  import plst_pkg::*;
#(
  parameter int LINKS = LINKS_DEF,
  parameter int WORDW = ADDR_BITS_DEF + ST_W + 1
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(LINKS)-1:0] wr_idx,
  input  logic [WORDW-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(LINKS)-1:0] rd_idx,
  output logic [WORDW-1:0]         rd_data
);

  logic [WORDW-1:0] ram [LINKS];

  // Write entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ram[wr_idx] <= wr_data;
    end
  end

  // Read entry into the registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= ram[rd_idx];
    end
  end

endmodule

// ===== rtl/core/plst_ctrl.sv =====
// ----------------------------------------------------------------------------
// plst_ctrl
// Sequencer for the link table: clearing pass after reset, linear scan for
// the matching and the first free entry, then one read-modify-write step
// that applies the link rules and builds the result word.
// ----------------------------------------------------------------------------
module plst_ctrl
  import plst_pkg::*;
#(
  parameter int LINKS     = LINKS_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  plst_in_t                 in_data,
  // result toward the output register
  output logic                     res_vld,
  output plst_out_t                res_data,
  input  logic                     res_take,
  // entry store
  output logic                     mem_wr_en,
  output logic [$clog2(LINKS)-1:0] mem_wr_idx,
  output logic [ADDR_BITS+ST_W:0]  mem_wr_data,
  output logic                     mem_rd_en,
  output logic [$clog2(LINKS)-1:0] mem_rd_idx,
  input  logic [ADDR_BITS+ST_W:0]  mem_rd_data
);

  localparam int IDXW  = $clog2(LINKS);
  localparam int CNTW  = $clog2(LINKS + 1);
  localparam int WORDW = ADDR_BITS + ST_W + 1;
  localparam logic [CNTW-1:0] SC_END  = CNTW'(LINKS);
  localparam logic [CNTW-1:0] SC_LAST = CNTW'(LINKS - 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_WRITE = 5'b01000,
    S_DONE  = 5'b10000
  } plst_fsm_t;

  plst_fsm_t            state_r, state_nxt;
  logic [CNTW-1:0]      sc_r, sc_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic [IDXW-1:0]      rd_idx_r, rd_idx_nxt;
  logic                 hit_r, hit_nxt;
  logic [IDXW-1:0]      hit_idx_r, hit_idx_nxt;
  logic [ST_W-1:0]      hit_st_r, hit_st_nxt;
  logic                 free_r, free_nxt;
  logic [IDXW-1:0]      free_idx_r, free_idx_nxt;
  plst_in_t             ev_r, ev_nxt;
  logic [ADDR_BITS-1:0] key_r, key_nxt;
  logic [CNTW-1:0]      cnt_r, cnt_nxt;
  plst_out_t            res_r, res_nxt;

  // Fields of the word coming back from the store
  logic                 ent_valid;
  logic [ADDR_BITS-1:0] ent_addr;
  logic [ST_W-1:0]      ent_st;

  // Rule decision
  logic            dec_touch;
  logic            dec_add;
  logic            dec_rem;
  logic            dec_full;
  logic [ST_W-1:0] dec_st;
  logic [ST_W-1:0] cur_st;
  logic            have_slot;
  logic            keep;
  logic [IDXW-1:0] slot;

  assign ent_valid = mem_rd_data[WORDW-1];
  assign ent_addr  = mem_rd_data[ST_W +: ADDR_BITS];
  assign ent_st    = mem_rd_data[ST_W-1:0];

  assign in_stall = (state_r != S_IDLE);
  assign res_vld  = (state_r == S_DONE);
  assign res_data = res_r;

  // Issue reads while the scan counter has entries left
  assign mem_rd_en  = (state_r == S_SCAN) && (sc_r != SC_END);
  assign mem_rd_idx = sc_r[IDXW-1:0];

  // Apply the link rules to the entry found by the scan
  always_comb begin
    cur_st    = hit_r ? hit_st_r : ST_IDLE;
    have_slot = hit_r || free_r;
    dec_touch = 1'b0;
    dec_add   = 1'b0;
    dec_rem   = 1'b0;
    dec_full  = 1'b0;
    dec_st    = ST_DISCONNECTED;
    case (ev_r.kind)
      KIND_USER_CONN: begin
        if (!have_slot) begin
          dec_full = 1'b1;
        end else begin
          dec_touch = 1'b1;
          case (cur_st) inside
            ST_IDLE, ST_DISCONNECTED: begin
              dec_add = 1'b1;
              dec_st  = ev_r.lower_ok ? ST_CONNECTING : ST_DISCONNECTED;
            end
            ST_CONNECTING, ST_CONNECTED, ST_DISCONNECTING: begin
              dec_st = cur_st;
            end
            default: begin
              dec_st = ST_IDLE;
            end
          endcase
        end
      end
      KIND_USER_DISC: begin
        if (hit_r) begin
          dec_touch = 1'b1;
          case (cur_st) inside
            ST_IDLE, ST_DISCONNECTED: begin
              dec_st = ST_DISCONNECTED;
            end
            ST_CONNECTED: begin
              dec_rem = 1'b1;
              dec_st  = ev_r.lower_ok ? ST_DISCONNECTING : ST_DISCONNECTED;
            end
            ST_CONNECTING, ST_DISCONNECTING: begin
              dec_st = cur_st;
            end
            default: begin
              dec_st = ST_IDLE;
            end
          endcase
        end
      end
      KIND_RPT_CONN: begin
        if (have_slot) begin
          dec_touch = 1'b1;
          dec_st    = ST_CONNECTED;
        end else begin
          dec_full = 1'b1;
        end
      end
      default: begin
        // report disconnected: drop a known entry
        dec_touch = hit_r;
      end
    endcase
    keep = (dec_st != ST_DISCONNECTED);
    slot = hit_r ? hit_idx_r : free_idx_r;
  end

  // Store write port: clearing pass or write-back
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_idx  = slot;
    mem_wr_data = {keep, key_r, dec_st};
    if (state_r == S_CLEAR) begin
      mem_wr_en   = 1'b1;
      mem_wr_idx  = sc_r[IDXW-1:0];
      mem_wr_data = '0;
    end else if (state_r == S_WRITE) begin
      mem_wr_en = dec_touch;
    end
  end

  // Next state
  always_comb begin
    state_nxt    = state_r;
    sc_nxt       = sc_r;
    rd_vld_nxt   = 1'b0;
    rd_idx_nxt   = rd_idx_r;
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    hit_st_nxt   = hit_st_r;
    free_nxt     = free_r;
    free_idx_nxt = free_idx_r;
    ev_nxt       = ev_r;
    key_nxt      = key_r;
    cnt_nxt      = cnt_r;
    res_nxt      = res_r;
    unique case (state_r)
      S_CLEAR: begin
        sc_nxt = sc_r + CNTW'(1);
        if (sc_r == SC_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          ev_nxt    = in_data;
          key_nxt   = ADDR_BITS'(in_data.peer_addr);
          sc_nxt    = '0;
          hit_nxt   = 1'b0;
          free_nxt  = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // advance the read pointer
        if (mem_rd_en) begin
          sc_nxt = sc_r + CNTW'(1);
        end
        rd_vld_nxt = mem_rd_en;
        rd_idx_nxt = sc_r[IDXW-1:0];
        // note the match and the first free entry
        if (rd_vld_r) begin
          if (ent_valid && (ent_addr == key_r) && !hit_r) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = rd_idx_r;
            hit_st_nxt  = ent_st;
          end
          if (!ent_valid && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = rd_idx_r;
          end
        end
        if (!mem_rd_en && !rd_vld_r) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        if (dec_touch && !hit_r && keep) begin
          cnt_nxt = cnt_r + CNTW'(1);
        end else if (dec_touch && hit_r && !keep) begin
          cnt_nxt = cnt_r - CNTW'(1);
        end
        res_nxt.link_state     = dec_st;
        res_nxt.issue_add      = dec_add;
        res_nxt.issue_remove   = dec_rem;
        res_nxt.cmd_frame_type = dec_add ? ev_r.frame_type : '0;
        res_nxt.table_full     = dec_full;
        res_nxt.all_clear      = (cnt_nxt == '0);
        state_nxt              = S_DONE;
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      sc_r     <= '0;
      rd_vld_r <= 1'b0;
      hit_r    <= 1'b0;
      free_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      sc_r     <= sc_nxt;
      rd_vld_r <= rd_vld_nxt;
      hit_r    <= hit_nxt;
      free_r   <= free_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_st_r   <= hit_st_nxt;
    free_idx_r <= free_idx_nxt;
    ev_r       <= ev_nxt;
    key_r      <= key_nxt;
    res_r      <= res_nxt;
  end

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= SC_END)
    else $error("valid entry count exceeds table size");

  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_SCAN) && !hit_r && !free_r)
    else $error("accepted word did not start a fresh scan");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !mem_wr_en)
    else $error("store written during scan");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (cnt_r == $past(cnt_r)) || (cnt_r == $past(cnt_r) + CNTW'(1)) ||
                     (cnt_r == $past(cnt_r) - CNTW'(1)))
    else $error("entry count moved by more than one");

  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !res_take) |=> (state_r == S_DONE) && $stable(res_r))
    else $error("pending result changed before it was taken");

endmodule

// ===== rtl/core/peer_link_state_table_top.sv =====
// ----------------------------------------------------------------------------
// peer_link_state_table_top
// Peer link state table: address lookup, entry allocation and per-link
// state stepping for connect and disconnect events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall / in_data carries one event word
//   (kind, peer address, frame type, lower-layer outcome). Result channel
//   out_valid / out_stall / out_data gives exactly one result word per event.
//   A word moves when valid is high and stall is low.
//   Each event scans the entry store one entry per cycle through its single
//   read port (LINKS reads, then the outstanding reads drain), then passes
//   through the write-back state and the result state, where the result
//   waits until the output register takes it, and returns to idle. A new
//   event is taken only in idle. After reset the block runs a clearing pass
//   over all LINKS store entries, with in_stall high, before the first event
//   is taken.
//   The result sits in an output register, so the next event is accepted
//   and worked on while out_stall holds the previous result; a second
//   finished result waits inside until the output register frees up.
// ----------------------------------------------------------------------------
module peer_link_state_table_top
  import plst_pkg::*;
#(
  parameter int LINKS     = LINKS_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  plst_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output plst_out_t out_data
);

  localparam int IDXW  = $clog2(LINKS);
  localparam int WORDW = ADDR_BITS + ST_W + 1;

  logic             res_vld;
  plst_out_t        res_data;
  logic             res_take;
  logic             mem_wr_en;
  logic [IDXW-1:0]  mem_wr_idx;
  logic [WORDW-1:0] mem_wr_data;
  logic             mem_rd_en;
  logic [IDXW-1:0]  mem_rd_idx;
  logic [WORDW-1:0] mem_rd_data;

  logic      out_valid_r;
  plst_out_t out_data_r;

  plst_ctrl #(
    .LINKS     (LINKS),
    .ADDR_BITS (ADDR_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .res_vld     (res_vld),
    .res_data    (res_data),
    .res_take    (res_take),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_idx  (mem_wr_idx),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_idx  (mem_rd_idx),
    .mem_rd_data (mem_rd_data)
  );

  plst_mem #(
    .LINKS (LINKS),
    .WORDW (WORDW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_idx  (mem_wr_idx),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_idx  (mem_rd_idx),
    .rd_data (mem_rd_data)
  );

  // Load the output register when it is empty or being drained
  assign res_take = res_vld && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Hold the word while stalled
  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== dv/plst_scoreboard_pkg.sv =====
// ----------------------------------------------------------------------------
// plst_scoreboard_pkg
// Scoreboard for the peer link state table: keeps its own copy of the link
// table, predicts one result word per accepted event word and checks the
// result words in order.
// ----------------------------------------------------------------------------
package plst_scoreboard_pkg;

  import plst_pkg::*;

  localparam int TABLE_SIZE = LINKS_DEF;

  class link_table_scoreboard;

    bit                 entry_used [TABLE_SIZE];
    logic [PADDR_W-1:0] entry_key  [TABLE_SIZE];
    logic [ST_W-1:0]    entry_st   [TABLE_SIZE];
    int                 used_entries;
    plst_out_t          expected_results [$];
    int                 failures;

    function new();
      for (int i = 0; i < TABLE_SIZE; i++) begin
        entry_used[i] = 1'b0;
        entry_key[i]  = '0;
        entry_st[i]   = ST_IDLE;
      end
      used_entries = 0;
      failures     = 0;
    endfunction

    // Take the lowest free entry, or return -1 when the table is full
    function int claim_entry(logic [PADDR_W-1:0] key);
      for (int i = 0; i < TABLE_SIZE; i++) begin
        if (!entry_used[i]) begin
          entry_used[i] = 1'b1;
          entry_key[i]  = key;
          entry_st[i]   = ST_IDLE;
          used_entries++;
          return i;
        end
      end
      return -1;
    endfunction

    function void release_entry(int slot);
      if (entry_used[slot]) used_entries--;
      entry_used[slot] = 1'b0;
      entry_key[slot]  = '0;
      entry_st[slot]   = ST_IDLE;
    endfunction

    // Step the table for one accepted event word and queue the result word
    function void note_event(plst_in_t ev);
      int              slot;
      logic [ST_W-1:0] cur;
      plst_out_t       res;
      res            = '0;
      res.link_state = ST_DISCONNECTED;
      slot           = -1;
      for (int i = 0; i < TABLE_SIZE; i++) begin
        if (slot < 0 && entry_used[i] && entry_key[i] == ev.peer_addr) slot = i;
      end
      case (ev.kind)
        KIND_USER_CONN: begin
          if (slot < 0) begin
            slot = claim_entry(ev.peer_addr);
            if (slot < 0) res.table_full = 1'b1;
          end
          if (slot >= 0) begin
            cur = entry_st[slot];
            if (cur == ST_IDLE || cur == ST_DISCONNECTED) begin
              res.issue_add      = 1'b1;
              res.cmd_frame_type = ev.frame_type;
              res.link_state     = ev.lower_ok ? ST_CONNECTING : ST_DISCONNECTED;
            end else if (cur == ST_CONNECTING || cur == ST_CONNECTED ||
                         cur == ST_DISCONNECTING) begin
              res.link_state = cur;
            end else begin
              res.link_state = ST_IDLE;
            end
            entry_st[slot] = res.link_state;
            if (res.link_state == ST_DISCONNECTED) release_entry(slot);
          end
        end
        KIND_USER_DISC: begin
          if (slot >= 0) begin
            cur = entry_st[slot];
            if (cur == ST_IDLE || cur == ST_DISCONNECTED) begin
              res.link_state = ST_DISCONNECTED;
            end else if (cur == ST_CONNECTED) begin
              res.issue_remove = 1'b1;
              res.link_state   = ev.lower_ok ? ST_DISCONNECTING : ST_DISCONNECTED;
            end else if (cur == ST_CONNECTING || cur == ST_DISCONNECTING) begin
              res.link_state = cur;
            end else begin
              res.link_state = ST_IDLE;
            end
            entry_st[slot] = res.link_state;
            if (res.link_state == ST_DISCONNECTED) release_entry(slot);
          end
        end
        KIND_RPT_CONN: begin
          if (slot < 0) begin
            slot = claim_entry(ev.peer_addr);
            if (slot < 0) res.table_full = 1'b1;
          end
          if (slot >= 0) begin
            entry_st[slot] = ST_CONNECTED;
            res.link_state = ST_CONNECTED;
          end
        end
        KIND_RPT_DISC: begin
          if (slot >= 0) release_entry(slot);
        end
      endcase
      res.all_clear = (used_entries == 0);
      expected_results.push_back(res);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got,
                                time stamp);
      if (got !== want) begin
        $display("%0t: %s expected %0h actual %0h", stamp, name, want, got);
        failures++;
      end
    endfunction

    // Check one accepted result word against the oldest prediction
    function void check_result(plst_out_t got, time stamp);
      plst_out_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result word with no event pending, expected none actual %h",
                 stamp, got);
        failures++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("link_state", want.link_state, got.link_state, stamp);
      compare_field("issue_add", want.issue_add, got.issue_add, stamp);
      compare_field("issue_remove", want.issue_remove, got.issue_remove, stamp);
      compare_field("cmd_frame_type", want.cmd_frame_type, got.cmd_frame_type, stamp);
      compare_field("table_full", want.table_full, got.table_full, stamp);
      compare_field("all_clear", want.all_clear, got.all_clear, stamp);
    endfunction

  endclass

endpackage

// ===== dv/peer_link_state_table_top_tb.sv =====
// ----------------------------------------------------------------------------
// peer_link_state_table_top_tb
// Drives connect, disconnect and lower-layer report words into the peer link
// state table, with bursty input and a stalling receiver, and checks every
// result word against the scoreboard's own copy of the table.
// ----------------------------------------------------------------------------
module peer_link_state_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import plst_pkg::*;
  import plst_scoreboard_pkg::*;

  localparam int POOL_SIZE   = 10;
  localparam int FILL_COUNT  = TABLE_SIZE + 8;
  localparam int DRAIN_WAIT  = TABLE_SIZE + 16;
  localparam int CYCLE_LIMIT = 1000000;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  plst_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  plst_out_t out_data;

  link_table_scoreboard sb = new();

  int                 burst_left  = 0;
  int                 stall_span  = 0;
  int                 cycle_count = 0;
  logic [PADDR_W-1:0] addr_pool [POOL_SIZE];
  logic [PADDR_W-1:0] fill_addrs [$];

  peer_link_state_table_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Stall the result channel in segments: short, long and quiet stretches
  always @(posedge clk) begin
    if (stall_span > 0) begin
      stall_span <= stall_span - 1;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          out_stall  <= 1'b0;
          stall_span <= $urandom_range(0, 30);
        end
        5, 6, 7: begin
          out_stall  <= 1'b1;
          stall_span <= $urandom_range(0, 5);
        end
        8: begin
          out_stall  <= 1'b1;
          stall_span <= $urandom_range(10, 40);
        end
        default: begin
          out_stall  <= 1'b0;
          stall_span <= $urandom_range(100, 400);
        end
      endcase
    end
  end

  // Check each accepted result word
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data, $time);
  end

  function automatic logic [PADDR_W-1:0] rand_addr();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[PADDR_W-1:0];
  endfunction

  // Offer one event word, hold it until accepted, then idle between bursts
  task automatic send_event(input logic [KIND_W-1:0] kind, input logic [PADDR_W-1:0] addr,
                            input logic [FTYPE_W-1:0] ftype, input logic ok);
    plst_in_t ev;
    int       gap;
    ev.kind       = kind;
    ev.peer_addr  = addr;
    ev.frame_type = ftype;
    ev.lower_ok   = ok;
    in_data  <= ev;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_event(ev);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 5);
    end
  endtask

  // Random events, mostly on a small set of peers so links walk their states
  task automatic run_pool_round(input int count);
    int                 pick;
    logic [KIND_W-1:0]  kind;
    logic [PADDR_W-1:0] addr;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35)      kind = KIND_USER_CONN;
      else if (pick < 60) kind = KIND_USER_DISC;
      else if (pick < 80) kind = KIND_RPT_CONN;
      else                kind = KIND_RPT_DISC;
      addr = ($urandom_range(0, 9) == 0) ? rand_addr()
                                         : addr_pool[$urandom_range(0, POOL_SIZE - 1)];
      send_event(kind, addr, FTYPE_W'($urandom), $urandom_range(0, 4) != 0);
    end
  endtask

  initial begin
    logic [PADDR_W-1:0] pa;
    logic [PADDR_W-1:0] pb;
    logic [PADDR_W-1:0] pc;
    logic [PADDR_W-1:0] swap;
    int                 j;

    // Peer set: both address extremes and near neighbors of one random key
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    addr_pool[2] = rand_addr();
    addr_pool[3] = addr_pool[2] ^ PADDR_W'(1);
    addr_pool[4] = addr_pool[2] ^ (PADDR_W'(1) << (PADDR_W - 1));
    for (int i = 5; i < POOL_SIZE; i++) addr_pool[i] = rand_addr();
    pa = addr_pool[0];
    pb = addr_pool[1];
    pc = addr_pool[2];

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Unknown peer: disconnect and report disconnected on an empty table
    send_event(KIND_USER_DISC, pa, 8'h00, 1'b1);
    send_event(KIND_RPT_DISC,  pa, 8'h00, 1'b1);
    // Walk one link through every state and the holds in each
    send_event(KIND_USER_CONN, pa, 8'hFF, 1'b1);
    send_event(KIND_USER_CONN, pa, 8'h00, 1'b1);
    send_event(KIND_USER_DISC, pa, 8'h00, 1'b1);
    send_event(KIND_RPT_CONN,  pa, 8'h00, 1'b0);
    send_event(KIND_USER_CONN, pa, 8'h3C, 1'b1);
    send_event(KIND_USER_DISC, pa, 8'h00, 1'b1);
    send_event(KIND_USER_DISC, pa, 8'h00, 1'b1);
    send_event(KIND_USER_CONN, pa, 8'hA5, 1'b0);
    send_event(KIND_RPT_CONN,  pa, 8'h00, 1'b1);
    // Lower layer refuses the remove, then the add
    send_event(KIND_USER_DISC, pa, 8'h00, 1'b0);
    send_event(KIND_USER_CONN, pb, 8'h5A, 1'b0);
    // Reports allocate; neighbor keys must not alias
    send_event(KIND_RPT_CONN,  pb, 8'hFF, 1'b1);
    send_event(KIND_RPT_CONN,  addr_pool[3] ^ addr_pool[2] ^ pb, 8'h00, 1'b0);
    send_event(KIND_RPT_CONN,  pc, 8'h00, 1'b1);
    // Free the lowest entry and reuse it
    send_event(KIND_RPT_DISC,  pb, 8'h00, 1'b1);
    send_event(KIND_USER_CONN, pa, 8'hFF, 1'b1);
    send_event(KIND_RPT_DISC,  pc, 8'h00, 1'b0);
    send_event(KIND_RPT_DISC,  addr_pool[3] ^ addr_pool[2] ^ pb, 8'h00, 1'b1);
    send_event(KIND_USER_DISC, pa, 8'h00, 1'b1);
    send_event(KIND_RPT_DISC,  pa, 8'h00, 1'b1);

    run_pool_round(180);

    // Fill the table past capacity with fresh peers
    for (int n = 0; n < FILL_COUNT; n++) begin
      fill_addrs.push_back(rand_addr());
      send_event(KIND_RPT_CONN, fill_addrs[n], FTYPE_W'($urandom), 1'($urandom));
    end
    // Full table: new peers are refused, known peers still step
    for (int n = 0; n < 6; n++) begin
      send_event(($urandom_range(0, 1) != 0) ? KIND_USER_CONN : KIND_RPT_CONN,
                 rand_addr(), FTYPE_W'($urandom), 1'($urandom));
    end
    run_pool_round(10);
    // Free entries in the middle and let new peers take them
    for (int n = 0; n < 8; n++) begin
      send_event(KIND_USER_DISC, fill_addrs[$urandom_range(0, FILL_COUNT - 1)],
                 FTYPE_W'($urandom), 1'($urandom));
      send_event(KIND_USER_CONN, rand_addr(), FTYPE_W'($urandom), 1'($urandom));
    end
    // Drain the fresh peers in random order
    for (int i = FILL_COUNT - 1; i > 0; i--) begin
      j             = $urandom_range(0, i);
      swap          = fill_addrs[i];
      fill_addrs[i] = fill_addrs[j];
      fill_addrs[j] = swap;
    end
    foreach (fill_addrs[i]) begin
      send_event(KIND_RPT_DISC, fill_addrs[i], FTYPE_W'($urandom), 1'($urandom));
    end

    run_pool_round(180);

    // Wait out the last results, then a full event time more
    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
